// ----- hw/rtl/shtst_pkg.sv -----
// package for the segment hit test block
// widths and defaults shared by front end, queue, back end and top level
package shtst_pkg;

  localparam int unsigned PortBits      = 32;
  localparam int unsigned CoordBitsDef  = 32;
  localparam int unsigned DistBits      = 31;
  localparam int unsigned DistSqBits    = 2 * DistBits;
  localparam int unsigned QueueDepthDef = 2;

endpackage

// ----- hw/rtl/shtst_front.sv -----
// front end: takes a transfer, sign-extends coordinates, forms segment and point vectors
// depends on shtst_pkg
module shtst_front #(
  parameter int unsigned COORD_BITS = shtst_pkg::CoordBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [shtst_pkg::PortBits-1:0]       ref_x_i,
  input  logic [shtst_pkg::PortBits-1:0]       ref_y_i,
  input  logic [shtst_pkg::PortBits-1:0]       start_x_i,
  input  logic [shtst_pkg::PortBits-1:0]       start_y_i,
  input  logic [shtst_pkg::PortBits-1:0]       end_x_i,
  input  logic [shtst_pkg::PortBits-1:0]       end_y_i,
  input  logic [shtst_pkg::DistBits-1:0]       max_dist_i,
  output logic                                 vec_valid_o,
  input  logic                                 vec_stall_i,
  output logic [6*(COORD_BITS+1)+shtst_pkg::DistBits-1:0] vec_o
);

  localparam int unsigned W  = COORD_BITS + 1;
  localparam int unsigned VW = 6 * W + shtst_pkg::DistBits;

  logic          valid_q, valid_d;
  logic [VW-1:0] vec_q, vec_d;
  logic          take;

  logic signed [W-1:0] rx, ry, sx, sy, ex, ey;

  assign rx = $signed({ref_x_i[COORD_BITS-1],   ref_x_i[COORD_BITS-1:0]});
  assign ry = $signed({ref_y_i[COORD_BITS-1],   ref_y_i[COORD_BITS-1:0]});
  assign sx = $signed({start_x_i[COORD_BITS-1], start_x_i[COORD_BITS-1:0]});
  assign sy = $signed({start_y_i[COORD_BITS-1], start_y_i[COORD_BITS-1:0]});
  assign ex = $signed({end_x_i[COORD_BITS-1],   end_x_i[COORD_BITS-1:0]});
  assign ey = $signed({end_y_i[COORD_BITS-1],   end_y_i[COORD_BITS-1:0]});

  assign in_stall_o = valid_q && vec_stall_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    vec_d   = vec_q;
    if (valid_q && !vec_stall_i) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d = 1'b1;
      vec_d   = {W'(ex - sx), W'(ey - sy), W'(rx - sx), W'(ry - sy),
                 W'(rx - ex), W'(ry - ey), max_dist_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q <= vec_d;
  end

  assign vec_valid_o = valid_q;
  assign vec_o       = vec_q;

endmodule

// ----- hw/rtl/shtst_queue.sv -----
// short queue between front end and back end
// depends on shtst_pkg
module shtst_queue #(
  parameter int unsigned DATA_BITS = 8,
  parameter int unsigned DEPTH     = shtst_pkg::QueueDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_valid_i,
  output logic                 wr_stall_o,
  input  logic [DATA_BITS-1:0] wr_data_i,
  output logic                 rd_valid_o,
  input  logic                 rd_stall_i,
  output logic [DATA_BITS-1:0] rd_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DATA_BITS-1:0] mem_q [DEPTH];
  logic [AW-1:0]        wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 wr, rd;

  assign wr_stall_o = (cnt_q == CW'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign wr         = wr_valid_i && !wr_stall_o;
  assign rd         = rd_valid_o && !rd_stall_i;
  assign rd_data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : AW'(wptr_q + 1'b1);
    end
    if (rd) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : AW'(rptr_q + 1'b1);
    end
    if (wr && !rd) begin
      cnt_d = CW'(cnt_q + 1'b1);
    end else if (rd && !wr) begin
      cnt_d = CW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

// ----- hw/rtl/shtst_back.sv -----
// back end: five-stage product, sum, split-multiply, accumulate and compare pipeline
// depends on shtst_pkg
module shtst_back #(
  parameter int unsigned COORD_BITS = shtst_pkg::CoordBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 vec_valid_i,
  output logic                                 vec_stall_o,
  input  logic [6*(COORD_BITS+1)+shtst_pkg::DistBits-1:0] vec_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 hit_o
);

  localparam int unsigned W    = COORD_BITS + 1;
  localparam int unsigned PW   = 2 * W;
  localparam int unsigned SW   = PW + 1;
  localparam int unsigned DB   = shtst_pkg::DistBits;
  localparam int unsigned D2B  = shtst_pkg::DistSqBits;
  localparam int unsigned DLB  = D2B - DB;
  localparam int unsigned CMPW = (SW > D2B) ? SW : D2B;
  localparam int unsigned TW   = (2 * PW > D2B + PW) ? 2 * PW : D2B + PW;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  logic signed [W-1:0] dx, dy, px, py, qx, qy;
  logic [DB-1:0]       lim;

  assign {dx, dy, px, py, qx, qy, lim} = vec_i;

  assign en          = !(v5_q && out_stall_i);
  assign vec_stall_o = !en;

  // products
  logic signed [PW-1:0] dxdx_q, dydy_q, dxpx_q, dypy_q, dxpy_q, dypx_q;
  logic signed [PW-1:0] pxpx_q, pypy_q, qxqx_q, qyqy_q;
  logic [D2B-1:0]       d2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dxdx_q <= PW'($signed(PW'(dx)) * $signed(PW'(dx)));
      dydy_q <= PW'($signed(PW'(dy)) * $signed(PW'(dy)));
      dxpx_q <= PW'($signed(PW'(dx)) * $signed(PW'(px)));
      dypy_q <= PW'($signed(PW'(dy)) * $signed(PW'(py)));
      dxpy_q <= PW'($signed(PW'(dx)) * $signed(PW'(py)));
      dypx_q <= PW'($signed(PW'(dy)) * $signed(PW'(px)));
      pxpx_q <= PW'($signed(PW'(px)) * $signed(PW'(px)));
      pypy_q <= PW'($signed(PW'(py)) * $signed(PW'(py)));
      qxqx_q <= PW'($signed(PW'(qx)) * $signed(PW'(qx)));
      qyqy_q <= PW'($signed(PW'(qy)) * $signed(PW'(qy)));
      d2_q   <= D2B'(lim) * D2B'(lim);
    end
  end

  // sums and range checks
  logic signed [SW-1:0] len_s, dot_s, crs_s, ps_s, qs_s;
  logic [PW-1:0]        xmag_q, len_q;
  logic [D2B-1:0]       d2b_q;
  logic                 endhit2_q, segok2_q;

  assign len_s = SW'(dxdx_q) + SW'(dydy_q);
  assign dot_s = SW'(dxpx_q) + SW'(dypy_q);
  assign crs_s = SW'(dxpy_q) - SW'(dypx_q);
  assign ps_s  = SW'(pxpx_q) + SW'(pypy_q);
  assign qs_s  = SW'(qxqx_q) + SW'(qyqy_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      len_q     <= PW'(len_s);
      xmag_q    <= crs_s[SW-1] ? PW'(-crs_s) : PW'(crs_s);
      d2b_q     <= d2_q;
      endhit2_q <= (CMPW'(unsigned'(ps_s)) <= CMPW'(d2_q)) ||
                   (CMPW'(unsigned'(qs_s)) <= CMPW'(d2_q));
      segok2_q  <= (len_s != '0) && !dot_s[SW-1] && (dot_s <= len_s);
    end
  end

  // split partial products
  logic [PW-1:0]     xll_q, xlh_q, xhh_q;
  logic [DB+W-1:0]   dll_q, dlh_q;
  logic [DLB+W-1:0]  dhl_q, dhh_q;
  logic              endhit3_q, segok3_q;
  logic [W-1:0]      xl, xh, ll, lh;
  logic [DB-1:0]     d2l;
  logic [DLB-1:0]    d2h;

  assign xl  = xmag_q[W-1:0];
  assign xh  = xmag_q[PW-1:W];
  assign ll  = len_q[W-1:0];
  assign lh  = len_q[PW-1:W];
  assign d2l = d2b_q[DB-1:0];
  assign d2h = d2b_q[D2B-1:DB];

  always_ff @(posedge clk_i) begin
    if (en) begin
      xll_q     <= PW'(xl) * PW'(xl);
      xlh_q     <= PW'(xl) * PW'(xh);
      xhh_q     <= PW'(xh) * PW'(xh);
      dll_q     <= (DB + W)'(d2l) * (DB + W)'(ll);
      dlh_q     <= (DB + W)'(d2l) * (DB + W)'(lh);
      dhl_q     <= (DLB + W)'(d2h) * (DLB + W)'(ll);
      dhh_q     <= (DLB + W)'(d2h) * (DLB + W)'(lh);
      endhit3_q <= endhit2_q;
      segok3_q  <= segok2_q;
    end
  end

  // accumulate
  logic [TW-1:0] xx_q, dl_q;
  logic          endhit4_q, segok4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      xx_q      <= (TW'(xhh_q) << PW) + (TW'(xlh_q) << (W + 1)) + TW'(xll_q);
      dl_q      <= (TW'(dhh_q) << (DB + W)) + (TW'(dhl_q) << DB) +
                   (TW'(dlh_q) << W) + TW'(dll_q);
      endhit4_q <= endhit3_q;
      segok4_q  <= segok3_q;
    end
  end

  // compare into output register
  logic hit_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= endhit4_q || (segok4_q && (xx_q <= dl_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= vec_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  assign out_valid_o = v5_q;
  assign hit_o       = hit_q;

endmodule

// ----- hw/rtl/segment_hit_test_top.sv -----
// Segment hit test: reports whether a point lies within max_dist of a segment, using exact
// integer arithmetic. One test is accepted per clock cycle while in_stall_o is low; its result
// passes through the input register, the queue and the five back-end stages, whose widest work
// is the split 132-bit squared cross product against the scaled segment length. A stall on the
// result side holds the back end; the two-entry queue and the input register keep up to three
// further tests in flight before the input side is stalled.
// depends on shtst_pkg, shtst_front, shtst_queue, shtst_back
module segment_hit_test_top #(
  parameter int unsigned COORD_BITS  = shtst_pkg::CoordBitsDef,
  parameter int unsigned QUEUE_DEPTH = shtst_pkg::QueueDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [shtst_pkg::PortBits-1:0] ref_x_i,
  input  logic [shtst_pkg::PortBits-1:0] ref_y_i,
  input  logic [shtst_pkg::PortBits-1:0] start_x_i,
  input  logic [shtst_pkg::PortBits-1:0] start_y_i,
  input  logic [shtst_pkg::PortBits-1:0] end_x_i,
  input  logic [shtst_pkg::PortBits-1:0] end_y_i,
  input  logic [shtst_pkg::DistBits-1:0] max_dist_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           hit_o
);

  localparam int unsigned VW = 6 * (COORD_BITS + 1) + shtst_pkg::DistBits;

  logic          fr_valid, fr_stall, bk_valid, bk_stall;
  logic [VW-1:0] fr_vec, bk_vec;

  shtst_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .ref_x_i     (ref_x_i),
    .ref_y_i     (ref_y_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .max_dist_i  (max_dist_i),
    .vec_valid_o (fr_valid),
    .vec_stall_i (fr_stall),
    .vec_o       (fr_vec)
  );

  shtst_queue #(.DATA_BITS(VW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_stall_o (fr_stall),
    .wr_data_i  (fr_vec),
    .rd_valid_o (bk_valid),
    .rd_stall_i (bk_stall),
    .rd_data_o  (bk_vec)
  );

  shtst_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vec_valid_i (bk_valid),
    .vec_stall_o (bk_stall),
    .vec_i       (bk_vec),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hit_o       (hit_o)
  );

`ifndef ASSERT_OFF
  a_queue_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_valid && bk_stall |=> bk_valid)
    else $error("queue dropped a waiting transfer");
  a_front_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fr_valid && fr_stall |=> fr_valid)
    else $error("front end dropped a waiting transfer");
  a_back_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> bk_stall)
    else $error("back end took a transfer while its result was stalled");
`endif

endmodule
